// ===== hdl/arp_pkg.sv =====
// Shared types and constants for the up-mode note arpeggiator.
`default_nettype none

package arp_pkg;

  // Number of note numbers kept in the held-note map.
  localparam int NOTE_RANGE = 128;
  localparam int SCAN_W     = $clog2(NOTE_RANGE);

  localparam int NOTE_W     = 7;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = 8;
  localparam int STEP_W     = 24;
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(24000);

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_ON   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // Register index of the step length, taken from the byte address.
  localparam logic REG_STEP = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note;
  } in_req_t;

  typedef struct packed {
    logic              is_note_on;
    logic [NOTE_W-1:0] out_note;
    logic              last;
  } out_req_t;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLR,
    OP_TICK
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [NOTE_W-1:0] note;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_OFF,
    BK_SCAN,
    BK_ON
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/arp_front.sv =====
// Front end: takes input requests and turns them into commands for the queue.
`default_nettype none

module arp_front (
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire arp_pkg::in_req_t in_req,
  input  wire logic           q_full,
  output logic                q_push,
  output arp_pkg::cmd_t       q_cmd
);

  logic accept;
  logic in_range;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = ({1'b0, in_req.note} < (arp_pkg::NOTE_W + 1)'(arp_pkg::NOTE_RANGE));

  // Unused kind codes and notes beyond the map are dropped here.
  always_comb begin
    q_push      = 1'b0;
    q_cmd.op    = arp_pkg::OP_TICK;
    q_cmd.note  = in_req.note;
    priority if (in_req.kind == arp_pkg::KIND_ON) begin
      q_push   = accept && in_range;
      q_cmd.op = arp_pkg::OP_SET;
    end else if (in_req.kind == arp_pkg::KIND_OFF) begin
      q_push   = accept && in_range;
      q_cmd.op = arp_pkg::OP_CLR;
    end else if (in_req.kind == arp_pkg::KIND_TICK) begin
      q_push   = accept;
      q_cmd.op = arp_pkg::OP_TICK;
    end else begin
      q_push   = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arp_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
`default_nettype none

module arp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire arp_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output arp_pkg::cmd_t      head
);

  arp_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arp_back.sv =====
// Back end: held-note map, step timer, rank scan and result register.
`default_nettype none

module arp_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [arp_pkg::STEP_W-1:0]    step_samples,
  input  wire logic                          cmd_valid,
  input  wire arp_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output arp_pkg::out_req_t                  out_req
);

  arp_pkg::back_state_t state_r, state_nxt;

  logic [arp_pkg::NOTE_RANGE-1:0] map_r, map_nxt;
  logic [arp_pkg::CNT_W-1:0]      held_cnt_r, held_cnt_nxt;
  logic [arp_pkg::CNT_W-1:0]      step_idx_r, step_idx_nxt;
  logic [arp_pkg::STEP_W-1:0]     elapsed_r, elapsed_nxt;
  logic                           snd_vld_r, snd_vld_nxt;
  logic [arp_pkg::NOTE_W-1:0]     snd_note_r, snd_note_nxt;
  logic [arp_pkg::CNT_W-1:0]      rank_r, rank_nxt;
  logic [arp_pkg::CNT_W-1:0]      seen_r, seen_nxt;
  logic [arp_pkg::SCAN_W-1:0]     pos_r, pos_nxt;
  logic                           off_last_r, off_last_nxt;
  logic                           out_vld_r, out_vld_nxt;
  arp_pkg::out_req_t              out_q_r, out_q_nxt;

  logic                           slot_free;
  logic [arp_pkg::SCAN_W-1:0]     cmd_bit;
  logic [arp_pkg::CNT_W-1:0]      rank_sel;

  assign out_valid = out_vld_r;
  assign out_req   = out_q_r;
  assign slot_free = !out_vld_r || !out_stall;
  assign cmd_bit   = cmd.note[arp_pkg::SCAN_W-1:0];
  assign rank_sel  = (step_idx_r >= held_cnt_r) ? '0 : step_idx_r;

  always_comb begin
    state_nxt    = state_r;
    map_nxt      = map_r;
    held_cnt_nxt = held_cnt_r;
    step_idx_nxt = step_idx_r;
    elapsed_nxt  = elapsed_r;
    snd_vld_nxt  = snd_vld_r;
    snd_note_nxt = snd_note_r;
    rank_nxt     = rank_r;
    seen_nxt     = seen_r;
    pos_nxt      = pos_r;
    off_last_nxt = off_last_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_q_nxt    = out_q_r;
    cmd_pop      = 1'b0;

    unique case (state_r)
      arp_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            arp_pkg::OP_SET: begin
              if (!map_r[cmd_bit]) begin
                map_nxt[cmd_bit] = 1'b1;
                held_cnt_nxt     = held_cnt_r + 1'b1;
              end
            end
            arp_pkg::OP_CLR: begin
              if (map_r[cmd_bit]) begin
                map_nxt[cmd_bit] = 1'b0;
                held_cnt_nxt     = held_cnt_r - 1'b1;
              end
            end
            arp_pkg::OP_TICK: begin
              if (held_cnt_r == '0) begin
                step_idx_nxt = '0;
                elapsed_nxt  = step_samples;
                if (snd_vld_r) begin
                  off_last_nxt = 1'b1;
                  state_nxt    = arp_pkg::BK_OFF;
                end
              end else if (elapsed_r >= step_samples) begin
                elapsed_nxt  = arp_pkg::STEP_W'(1);
                rank_nxt     = rank_sel;
                step_idx_nxt = rank_sel + 1'b1;
                seen_nxt     = '0;
                pos_nxt      = '0;
                off_last_nxt = 1'b0;
                state_nxt    = snd_vld_r ? arp_pkg::BK_OFF : arp_pkg::BK_SCAN;
              end else begin
                elapsed_nxt  = elapsed_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      arp_pkg::BK_OFF: begin
        if (slot_free) begin
          out_vld_nxt          = 1'b1;
          out_q_nxt.is_note_on = 1'b0;
          out_q_nxt.out_note   = snd_note_r;
          out_q_nxt.last       = off_last_r;
          snd_vld_nxt          = 1'b0;
          state_nxt            = off_last_r ? arp_pkg::BK_IDLE : arp_pkg::BK_SCAN;
        end
      end

      arp_pkg::BK_SCAN: begin
        pos_nxt = pos_r + 1'b1;
        if (map_r[pos_r] && (seen_r == rank_r)) begin
          snd_note_nxt = arp_pkg::NOTE_W'(pos_r);
          state_nxt    = arp_pkg::BK_ON;
        end else begin
          if (map_r[pos_r]) begin
            seen_nxt = seen_r + 1'b1;
          end
          if (pos_r == arp_pkg::SCAN_W'(arp_pkg::NOTE_RANGE - 1)) begin
            snd_note_nxt = '0;
            state_nxt    = arp_pkg::BK_ON;
          end
        end
      end

      arp_pkg::BK_ON: begin
        if (slot_free) begin
          out_vld_nxt          = 1'b1;
          out_q_nxt.is_note_on = 1'b1;
          out_q_nxt.out_note   = snd_note_r;
          out_q_nxt.last       = 1'b1;
          snd_vld_nxt          = 1'b1;
          state_nxt            = arp_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= arp_pkg::BK_IDLE;
      map_r      <= '0;
      held_cnt_r <= '0;
      step_idx_r <= '0;
      elapsed_r  <= '0;
      snd_vld_r  <= 1'b0;
      snd_note_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      map_r      <= map_nxt;
      held_cnt_r <= held_cnt_nxt;
      step_idx_r <= step_idx_nxt;
      elapsed_r  <= elapsed_nxt;
      snd_vld_r  <= snd_vld_nxt;
      snd_note_r <= snd_note_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r     <= rank_nxt;
    seen_r     <= seen_nxt;
    pos_r      <= pos_nxt;
    off_last_r <= off_last_nxt;
    out_q_r    <= out_q_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/note_arpeggiator_up_unit.sv =====
// Top level of the up-mode note arpeggiator: front end, command queue, back end, register.
// Note-on and note-off requests set or clear one bit of a 128-entry held-note map and give
// no result; a tick request stands for one audio sample and advances the step timer. When
// a step starts, the unit releases the sounding note (a note-off result) and then sounds
// the held note at the current index in ascending note order (a note-on result with last
// set). With nothing held, a tick releases any sounding note and rearms the timer. Note
// requests and ticks that start no step are handled in the back end's idle state; a tick
// that starts a step then goes through the bit-serial scan of the held-note map that finds
// the note of the wanted rank and through a state for each emitted result. The two-entry
// command queue lets requests be taken while the back end scans, and the result register
// lets the back end go on while a result waits to be taken. The step length in samples is
// the single register at byte address 0 (24 bits, reset value 24000); write it only while
// the unit is idle.
`default_nettype none

module note_arpeggiator_up_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input request channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire arp_pkg::in_req_t                in_req,
  // Result request channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output arp_pkg::out_req_t                    out_req,
  // Register port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [arp_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [arp_pkg::PDATA_W-1:0]     pwdata,
  output logic [arp_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  logic [arp_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       q_push, q_full, q_not_empty, q_pop;
  arp_pkg::cmd_t              q_cmd, q_head;
  logic                       reg_hit;

  // The step length register sits at word 0; any other address reads as zero.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == arp_pkg::REG_STEP);
  assign prdata  = reg_hit ? arp_pkg::PDATA_W'(step_r) : '0;

  always_comb begin
    step_nxt = step_r;
    if (psel && penable && pwrite && reg_hit) begin
      step_nxt = pwdata[arp_pkg::STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= arp_pkg::STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  // The front end drops ignored requests and queues the rest in arrival order.
  arp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  arp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The back end owns all arpeggiator state and the result register.
  arp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_samples (step_r),
    .cmd_valid    (q_not_empty),
    .cmd          (q_head),
    .cmd_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_req      (out_req)
  );

endmodule

`default_nettype wire
